@@ rtl/smcp_pkg.sv @@
// Shared types and constants for the square matrix chain product block.
`timescale 1ns / 1ps
package smcp_pkg;
  localparam int ElemW   = 32;
  localparam int OrderW  = 4;
  localparam int CountW  = 8;
  localparam int CfgIdxW = 1;
  localparam int CfgDatW = 8;

  localparam logic [CfgIdxW-1:0] RegOrder = 1'd0;
  localparam logic [CfgIdxW-1:0] RegCount = 1'd1;

  typedef logic signed [ElemW-1:0] elem_t;

  typedef struct packed {
    logic signed [ElemW-1:0] product_value;
    logic                    last_element;
  } result_t;
endpackage

@@ rtl/smcp_if.sv @@
// Valid/ready channel interface carrying one payload item.
`timescale 1ns / 1ps
interface smcp_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/smcp_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module smcp_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

@@ rtl/square_matrix_chain_product.sv @@
// Top level of the square matrix chain product block.
// Usage: program matrix_order (index 0) and matrix_count (index 1) while idle.
// Elements of a chain arrive on the in_ channel in row-major order, one item
// each. The first matrix is stored as the running product; each later matrix
// is collected and then multiplied onto it from the right with one 32-bit
// multiply-accumulate per cycle. The multiply of a matrix starts once its last
// element is taken and is paced by the single MAC and the registered read data
// of the product and buffer memories; input is held off meanwhile.
// After the last matrix the product leaves on the out_ channel row-major; each
// item is read in StOut and registered in StOutW, the final one flagged
// by last_element. A stalled receiver holds the current item; nothing is lost.
// Reset returns order and count to 2 and both counters to zero. The memory
// contents are not cleared; a chain writes every entry before reading it.
// A configuration write clears the element and matrix counters.
`timescale 1ns / 1ps
module square_matrix_chain_product #(
  parameter int MAX_ORDER = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  smcp_if.sink                          in_ch,
  smcp_if.source                        out_ch,
  input  logic                          cfg_we,
  input  logic [smcp_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [smcp_pkg::CfgDatW-1:0]  cfg_data
);
  localparam int Cells = MAX_ORDER * MAX_ORDER;
  localparam int AW = (Cells > 1) ? $clog2(Cells) : 1;
  localparam int NW = $clog2(MAX_ORDER + 1);
  localparam int KW = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int CW = $clog2(Cells + 1);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StMac  = 3'd1;
  localparam logic [2:0] StWb   = 3'd2;
  localparam logic [2:0] StOut  = 3'd3;
  localparam logic [2:0] StOutW = 3'd4;

  logic [smcp_pkg::OrderW-1:0] order_r;
  logic [smcp_pkg::CountW-1:0] count_r;
  logic [2:0]    st_r;
  logic [CW-1:0] ecnt_r;
  logic [smcp_pkg::CountW-1:0] mcnt_r;
  logic [NW-1:0] n;
  logic [CW-1:0] cells;
  logic [smcp_pkg::CountW-1:0] ecount;

  always_comb begin
    if (order_r == '0) begin
      n = NW'(1);
    end else if (32'(order_r) > MAX_ORDER) begin
      n = NW'(MAX_ORDER);
    end else begin
      n = NW'(order_r);
    end
    cells  = CW'(n) * CW'(n);
    ecount = (count_r == '0) ? smcp_pkg::CountW'(1) : count_r;
  end

  // MAC sequencing: row r, column c, term k.
  logic [KW-1:0] r_r, c_r, k_r, wc_r;
  logic          rd_v_r, rd_last_r;
  logic [31:0]   acc_r;
  logic [31:0]   scr_r [MAX_ORDER];
  logic [31:0]   p_rd, m_rd;

  logic          p_we, m_we;
  logic [AW-1:0] p_wa, p_ra, m_ra, ea;
  logic [31:0]   p_wd;

  logic in_fire, out_fire, last_in;
  assign in_ch.ready = (st_r == StLoad) && !cfg_we;
  assign in_fire = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;
  assign ea = AW'(ecnt_r);
  assign last_in = (ecnt_r == cells - CW'(1));

  always_comb begin
    p_we = 1'b0;
    p_wa = ea;
    p_wd = in_ch.data;
    m_we = in_fire && (mcnt_r != '0);
    p_ra = AW'(32'(r_r) * 32'(n) + 32'(k_r));
    m_ra = AW'(32'(k_r) * 32'(n) + 32'(c_r));
    if (in_fire && mcnt_r == '0) begin
      p_we = 1'b1;
    end
    if (st_r == StWb) begin
      p_we = 1'b1;
      p_wa = AW'(32'(r_r) * 32'(n) + 32'(wc_r));
      p_wd = scr_r[wc_r];
    end
    if (st_r == StOut || st_r == StOutW) begin
      p_ra = ea;
    end
  end

  smcp_ram #(.Width(32), .Depth(Cells)) u_prod (
    .clk, .we(p_we), .waddr(p_wa), .wdata(p_wd), .raddr(p_ra), .rdata(p_rd));
  smcp_ram #(.Width(32), .Depth(Cells)) u_inc (
    .clk, .we(m_we), .waddr(ea), .wdata(in_ch.data), .raddr(m_ra), .rdata(m_rd));

  logic [31:0] out_val_r;
  logic        out_last_r, out_v_r;
  assign out_ch.valid = out_v_r;
  assign out_ch.data.product_value = out_val_r;
  assign out_ch.data.last_element = out_last_r;

  logic [NW-1:0] nm1;
  assign nm1 = n - NW'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r <= smcp_pkg::OrderW'(2);
      count_r <= smcp_pkg::CountW'(2);
      st_r <= StLoad;
      ecnt_r <= '0;
      mcnt_r <= '0;
      r_r <= '0; c_r <= '0; k_r <= '0; wc_r <= '0;
      rd_v_r <= 1'b0; rd_last_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (out_fire) out_v_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == smcp_pkg::RegOrder) order_r <= cfg_data[smcp_pkg::OrderW-1:0];
        else order_r <= order_r;
        if (cfg_index == smcp_pkg::RegCount) count_r <= cfg_data;
        ecnt_r <= '0;
        mcnt_r <= '0;
      end else begin
        case (st_r)
          StLoad: begin
            if (in_fire) begin
              if (!last_in) begin
                ecnt_r <= ecnt_r + CW'(1);
              end else begin
                ecnt_r <= '0;
                if (mcnt_r != '0) begin
                  st_r <= StMac;
                  r_r <= '0; c_r <= '0; k_r <= '0;
                  acc_r <= '0;
                end else if (ecount == smcp_pkg::CountW'(1)) begin
                  st_r <= StOut;
                  mcnt_r <= '0;
                end else begin
                  mcnt_r <= mcnt_r + smcp_pkg::CountW'(1);
                end
              end
            end
          end
          StMac: begin
            // Issue reads for (r,c,k); accumulate once the registered read data returns.
            if (rd_v_r && rd_last_r) begin
              scr_r[c_r] <= acc_r + p_rd * m_rd;
              acc_r <= '0;
              rd_v_r <= 1'b0;
              if (c_r == KW'(nm1)) begin
                st_r <= StWb;
                wc_r <= '0;
              end else begin
                c_r <= c_r + KW'(1);
                k_r <= '0;
              end
            end else begin
              if (rd_v_r) acc_r <= acc_r + p_rd * m_rd;
              rd_v_r <= 1'b1;
              rd_last_r <= (k_r == KW'(nm1));
              if (k_r != KW'(nm1)) k_r <= k_r + KW'(1);
            end
          end
          StWb: begin
            if (wc_r == KW'(nm1)) begin
              c_r <= '0; k_r <= '0;
              if (r_r == KW'(nm1)) begin
                if (mcnt_r + smcp_pkg::CountW'(1) >= ecount) begin
                  mcnt_r <= '0;
                  st_r <= StOut;
                end else begin
                  mcnt_r <= mcnt_r + smcp_pkg::CountW'(1);
                  st_r <= StLoad;
                end
              end else begin
                r_r <= r_r + KW'(1);
                st_r <= StMac;
              end
            end else begin
              wc_r <= wc_r + KW'(1);
            end
          end
          StOut: begin
            // Read address ecnt_r issued; data next cycle.
            if (!out_v_r || out_fire) st_r <= StOutW;
          end
          StOutW: begin
            out_val_r <= p_rd;
            out_last_r <= last_in;
            out_v_r <= 1'b1;
            if (last_in) begin
              ecnt_r <= '0;
              st_r <= StLoad;
            end else begin
              ecnt_r <= ecnt_r + CW'(1);
              st_r <= StOut;
            end
          end
          default: st_r <= StLoad;
        endcase
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> out_v_r)
    else $error("result dropped under stall");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r && !out_ch.ready |=> $stable(out_val_r) && $stable(out_last_r))
    else $error("output overwrite");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> st_r == StLoad)
    else $error("input taken while busy");
endmodule
